// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is held
`define SBTL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check, also live through reset
`define SBTL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== sv/sbtl_pkg.sv =====
// Types and constants for the scaled bitmap text layout block
`timescale 1ns / 1ps

package sbtl_pkg;

    localparam logic [7:0] GLYPH_FIRST = 8'd32;
    localparam logic [7:0] GLYPH_LAST  = 8'd126;
    localparam logic [7:0] CHAR_SUB    = 8'd63;
    localparam logic [7:0] CHAR_SPACE  = 8'd32;

    localparam int CELL_W   = 12;
    localparam int CELL_H   = 17;
    localparam int CELL_OFS = 2;
    localparam int DRAW_W   = 8;
    localparam int DRAW_H   = 13;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAWABLE_W = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAWABLE_H = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_W      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_H      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd5;

    localparam logic [13:0] RST_DRAWABLE_W = 14'd640;
    localparam logic [13:0] RST_DRAWABLE_H = 14'd480;
    localparam logic [15:0] RST_REF_W      = 16'd320;
    localparam logic [15:0] RST_REF_H      = 16'd200;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT,
        ST_EMIT
    } t_state;

    // setup steps, issued in this order; only OP_SW and OP_SH run on the divider
    typedef enum logic [2:0] {
        OP_SW,
        OP_SH,
        OP_RW,
        OP_RH,
        OP_OX,
        OP_OY,
        OP_GW,
        OP_GH
    } t_op;

    typedef struct packed {
        logic take;
        logic div_start;
        logic div_capture;
        logic emit;
        t_op  op;
    } t_dp_cmd;

    typedef struct packed {
        logic at_start;
        logic div_done;
        logic out_blocked;
    } t_dp_status;

endpackage

// ===== sv/sbtl_div.sv =====
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module sbtl_div #(
    parameter int NUM_W = 29
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [15:0]      i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CW = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [15:0]      r_rem;
    logic [15:0]      r_den;
    logic [NUM_W-1:0] r_quot;

    logic [16:0]      rem_sh;
    logic [16:0]      diff;
    logic             ge;
    logic [15:0]      n_rem;
    logic [NUM_W-1:0] n_quot;

    always_comb begin
        rem_sh = {r_rem, r_quot[NUM_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
        n_rem  = ge ? diff[15:0] : rem_sh[15:0];
        n_quot = {r_quot[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_den  <= i_den;
            r_quot <= i_num;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== sv/sbtl_ctrl.sv =====
// Controller: item handshake and sequencing of the string setup steps
`timescale 1ns / 1ps

module sbtl_ctrl
    import sbtl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    t_op    r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_SW;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state           = r_state;
        n_op              = r_op;
        o_cmd.take        = 1'b0;
        o_cmd.div_start   = 1'b0;
        o_cmd.div_capture = 1'b0;
        o_cmd.emit        = 1'b0;
        o_cmd.op          = r_op;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_op       = OP_SW;
                    n_state    = i_status.at_start ? ST_LOAD : ST_EMIT;
                end
            end
            ST_LOAD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_WAIT;
            end
            ST_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_capture = 1'b1;
                    if (r_op == OP_GH) begin
                        n_state = ST_EMIT;
                    end else begin
                        n_op    = t_op'(r_op + 3'd1);
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_EMIT: begin
                if (!i_status.out_blocked) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != ST_IDLE);

endmodule

// ===== sv/sbtl_dp.sv =====
// Datapath: config registers, scale setup, pen state and result register
`timescale 1ns / 1ps

module sbtl_dp
    import sbtl_pkg::*;
#(
    parameter int SCALE_ONE = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_text,
    input  logic                 i_stall,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    output logic                 o_valid,
    output logic                 o_glyph_present,
    output logic                 o_pen_overflow,
    output logic [6:0]           o_atlas_glyph,
    output logic signed [31:0]   o_screen_x,
    output logic signed [31:0]   o_screen_y,
    output logic [5:0]           o_dest_width,
    output logic [5:0]           o_dest_height,
    output logic [7:0]           o_atlas_x,
    output logic [6:0]           o_atlas_y
);

    localparam int SW       = $clog2(4 * SCALE_ONE + 1);
    localparam int N_W      = SW + 18;
    localparam int SCALE_SH = $clog2(SCALE_ONE);

    // configuration
    logic [13:0]        r_dw, r_dh;
    logic [15:0]        r_rw, r_rh;
    logic signed [15:0] r_ox, r_oy;

    // item
    logic [7:0] r_char;
    logic       r_last;

    // layout state
    logic [N_W-1:0]     r_sw;
    logic [SW-1:0]      r_scale;
    logic signed [31:0] r_srw, r_srh;
    logic signed [31:0] r_pen_x, r_pen_y;
    logic [5:0]         r_draw_w;   // also the pen advance: both are scaled(8)
    logic [5:0]         r_draw_h;
    logic signed [31:0] r_qs;
    logic               r_qdone;
    logic               r_at_start;
    logic               r_halted;

    // result
    logic               r_out_valid;
    logic               r_o_present, r_o_ovf;
    logic [6:0]         r_o_glyph;
    logic signed [31:0] r_o_x, r_o_y;
    logic [5:0]         r_o_w, r_o_h;
    logic [7:0]         r_o_ax;
    logic [6:0]         r_o_ay;

    // divider
    logic           div_go;
    logic [N_W-1:0] div_num;
    logic [15:0]    div_den;
    logic           div_done;
    logic [N_W-1:0] div_quot;

    logic [15:0]           rw_eff, rh_eff;
    logic signed [16:0]    opnd;
    logic signed [N_W-1:0] prod, sum, sum_adj;
    logic signed [31:0]    qs;

    logic [N_W-1:0]     smin;
    logic [SW-1:0]      scale_new;
    logic signed [31:0] dsub, d_adj, half, pen_start;
    logic [5:0]         gsz;

    logic [7:0]  c_eff;
    logic        is_glyph;
    logic [6:0]  g;
    logic [32:0] pen_sum;
    logic        ovf;

    assign div_go = i_cmd.div_start && (i_cmd.op == OP_SW || i_cmd.op == OP_SH);

    sbtl_div #(
        .NUM_W (N_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw <= RST_DRAWABLE_W;
            r_dh <= RST_DRAWABLE_H;
            r_rw <= RST_REF_W;
            r_rh <= RST_REF_H;
            r_ox <= '0;
            r_oy <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DRAWABLE_W: r_dw <= i_cfg_data[13:0];
                CFG_DRAWABLE_H: r_dh <= i_cfg_data[13:0];
                CFG_REF_W:      r_rw <= i_cfg_data;
                CFG_REF_H:      r_rh <= i_cfg_data;
                CFG_ORIGIN_X:   r_ox <= signed'(i_cfg_data);
                CFG_ORIGIN_Y:   r_oy <= signed'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // scale ratios go to the divider; scaled values add half a unit, then truncate toward zero
    always_comb begin
        rw_eff = (r_rw == 16'd0) ? 16'd1 : r_rw;
        rh_eff = (r_rh == 16'd0) ? 16'd1 : r_rh;
        case (i_cmd.op)
            OP_RW:   opnd = signed'({1'b0, rw_eff});
            OP_RH:   opnd = signed'({1'b0, rh_eff});
            OP_OX:   opnd = 17'(r_ox);
            OP_OY:   opnd = 17'(r_oy);
            OP_GW:   opnd = 17'(DRAW_W);
            OP_GH:   opnd = 17'(DRAW_H);
            default: opnd = '0;
        endcase
        prod    = N_W'(opnd) * N_W'(signed'({1'b0, r_scale}));
        sum     = prod + N_W'(SCALE_ONE / 2);
        sum_adj = sum + (sum[N_W-1] ? N_W'(SCALE_ONE - 1) : N_W'(0));
        qs      = 32'(sum_adj >>> SCALE_SH);
        case (i_cmd.op)
            OP_SW: begin
                div_num = N_W'(r_dw) * N_W'(SCALE_ONE);
                div_den = rw_eff;
            end
            OP_SH: begin
                div_num = N_W'(r_dh) * N_W'(SCALE_ONE);
                div_den = rh_eff;
            end
            default: begin
                div_num = '0;
                div_den = 16'd1;
            end
        endcase
    end

    // capture side of the setup steps
    always_comb begin
        smin = (r_sw < div_quot) ? r_sw : div_quot;
        if (smin >= N_W'(4 * SCALE_ONE)) begin
            scale_new = SW'(4 * SCALE_ONE);
        end else if (smin >= N_W'(3 * SCALE_ONE)) begin
            scale_new = SW'(3 * SCALE_ONE);
        end else if (smin >= N_W'(2 * SCALE_ONE)) begin
            scale_new = SW'(2 * SCALE_ONE);
        end else if (smin > N_W'(SCALE_ONE)) begin
            scale_new = SW'(SCALE_ONE);
        end else if (smin == '0) begin
            scale_new = SW'(1);
        end else begin
            scale_new = SW'(smin);
        end
        if (i_cmd.op == OP_OX) begin
            dsub = signed'(32'(r_dw)) - r_srw;
        end else begin
            dsub = signed'(32'(r_dh)) - r_srh;
        end
        d_adj     = dsub + 32'(dsub[31]);
        half      = d_adj >>> 1;
        pen_start = half + r_qs;
        gsz       = (r_qs == '0) ? 6'd1 : r_qs[5:0];
    end

    // per-byte work
    always_comb begin
        c_eff    = (r_char inside {[GLYPH_FIRST:GLYPH_LAST]}) ? r_char : CHAR_SUB;
        is_glyph = (c_eff != CHAR_SPACE);
        g        = 7'(c_eff - GLYPH_FIRST);
        pen_sum  = {r_pen_x[31], r_pen_x} + 33'(r_draw_w);
        ovf      = !pen_sum[32] && pen_sum[31];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_char <= i_char_code;
            r_last <= i_end_of_text;
        end
        if (i_cmd.div_start) begin
            r_qs <= qs;
        end
        if (i_cmd.div_capture) begin
            case (i_cmd.op)
                OP_SW:   r_sw     <= div_quot;
                OP_SH:   r_scale  <= scale_new;
                OP_RW:   r_srw    <= r_qs;
                OP_RH:   r_srh    <= r_qs;
                OP_OX:   r_pen_x  <= pen_start;
                OP_OY:   r_pen_y  <= pen_start;
                OP_GW:   r_draw_w <= gsz;
                OP_GH:   r_draw_h <= gsz;
                default: begin
                end
            endcase
        end
        if (i_cmd.emit && !r_halted) begin
            if (!ovf) begin
                r_pen_x <= pen_sum[31:0];
            end
            r_o_present <= is_glyph;
            r_o_ovf     <= ovf;
            if (is_glyph) begin
                r_o_glyph <= g;
                r_o_x     <= r_pen_x;
                r_o_y     <= r_pen_y;
                r_o_w     <= r_draw_w;
                r_o_h     <= r_draw_h;
                r_o_ax    <= 8'(g[3:0] * CELL_W + CELL_OFS);
                r_o_ay    <= 7'(g[6:4] * CELL_H + CELL_OFS);
            end else begin
                r_o_glyph <= '0;
                r_o_x     <= '0;
                r_o_y     <= '0;
                r_o_w     <= '0;
                r_o_h     <= '0;
                r_o_ax    <= '0;
                r_o_ay    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start  <= 1'b1;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
            r_qdone     <= 1'b0;
        end else begin
            r_qdone <= i_cmd.div_start && !div_go;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.div_capture && i_cmd.op == OP_GH) begin
                r_at_start <= 1'b0;
            end
            if (i_cmd.emit) begin
                if (!r_halted && (ovf || is_glyph)) begin
                    r_out_valid <= 1'b1;
                end
                if (!r_halted && ovf) begin
                    r_halted <= 1'b1;
                end
                if (r_last) begin
                    r_at_start <= 1'b1;
                    r_halted   <= 1'b0;
                end
            end
        end
    end

    assign o_status.at_start    = r_at_start;
    assign o_status.div_done    = div_done || r_qdone;
    assign o_status.out_blocked = r_out_valid && i_stall;

    assign o_valid         = r_out_valid;
    assign o_glyph_present = r_o_present;
    assign o_pen_overflow  = r_o_ovf;
    assign o_atlas_glyph   = r_o_glyph;
    assign o_screen_x      = r_o_x;
    assign o_screen_y      = r_o_y;
    assign o_dest_width    = r_o_w;
    assign o_dest_height   = r_o_h;
    assign o_atlas_x       = r_o_ax;
    assign o_atlas_y       = r_o_ay;

endmodule

// ===== sv/scaled_bitmap_text_layout_top.sv =====
// Top level of the scaled bitmap text layout block
`timescale 1ns / 1ps

// Takes one text byte per item and returns at most one glyph placement item
// (atlas cell, screen position, scaled size). The first byte of each string
// reads the config registers and works out the layout: the two scale ratios
// run on a restoring divider, one quotient bit per cycle, with an N-bit
// numerator, N = clog2(4 * SCALE_ONE + 1) + 18 (N = 29 at SCALE_ONE = 256,
// which must be a power of two), and then the six scaled values are formed
// in turn. Every other byte is accepted, then its result is formed. A finished
// result sits in an output register, so the next byte is taken while it waits;
// beyond that work the block stalls only while a new result is ready and that
// register is still held by the downstream side. Config writes made between
// strings take effect at the next string.

module scaled_bitmap_text_layout_top
    import sbtl_pkg::*;
#(
    parameter int SCALE_ONE = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_text,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_glyph_present,
    output logic                 o_pen_overflow,
    output logic [6:0]           o_atlas_glyph,
    output logic signed [31:0]   o_screen_x,
    output logic signed [31:0]   o_screen_y,
    output logic [5:0]           o_dest_width,
    output logic [5:0]           o_dest_height,
    output logic [7:0]           o_atlas_x,
    output logic [6:0]           o_atlas_y
);

    t_dp_cmd    cmd;
    t_dp_status status;

    sbtl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sbtl_dp #(
        .SCALE_ONE (SCALE_ONE)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_char_code     (i_char_code),
        .i_end_of_text   (i_end_of_text),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_glyph_present (o_glyph_present),
        .o_pen_overflow  (o_pen_overflow),
        .o_atlas_glyph   (o_atlas_glyph),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .o_dest_width    (o_dest_width),
        .o_dest_height   (o_dest_height),
        .o_atlas_x       (o_atlas_x),
        .o_atlas_y       (o_atlas_y)
    );

endmodule

// ===== sv/sbtl_chk.sv =====
// Port-level checks for the text layout top, bound to it
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbtl_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_glyph_present,
    input logic               o_pen_overflow,
    input logic [6:0]         o_atlas_glyph,
    input logic signed [31:0] o_screen_x
);

    `SBTL_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid, "result item dropped while stalled")
    `SBTL_ASSERT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall |=> $stable(o_screen_x) && $stable(o_atlas_glyph) && $stable(o_pen_overflow), "stalled result item changed")
    `SBTL_ASSERT(a_busy_after_take, i_clk, i_rst_n, i_valid && !o_stall |=> o_stall, "input taken again before item was handled")
    `SBTL_ASSERT(a_empty_is_ovf, i_clk, i_rst_n, o_valid && !o_glyph_present |-> o_pen_overflow, "result item without glyph or overflow")
    `SBTL_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_valid, "result valid after reset")

endmodule

bind scaled_bitmap_text_layout_top sbtl_chk u_chk (.*);
